// File: rtl/vhs_pkg.sv
// ----------------------------------------------------------------------------
// vhs_pkg
// Shared types and constants for the vial handling sequencer: state codes,
// actuator command codes, register indexes and the item structures.
// ----------------------------------------------------------------------------
package vhs_pkg;

    // Width of the internal vial counter (the result shows its low 16 bits)
    localparam int COUNT_BITS  = 16;

    localparam int TIME_W      = 19;
    localparam int ELAPSED_W   = 21;
    localparam int TICK_W      = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 32;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Register reset values
    localparam logic [TIME_W-1:0] LIFT_TIMEOUT_RST = TIME_W'(5000);
    localparam logic [TIME_W-1:0] REV_TIMEOUT_RST  = TIME_W'(5000);
    localparam logic [TIME_W-1:0] GRAB_WAIT_RST    = TIME_W'(500);
    localparam logic [TIME_W-1:0] LID_TIMEOUT_RST  = TIME_W'(5000);
    localparam logic [TIME_W-1:0] MEASURE_TIME_RST = TIME_W'(10000);

    typedef enum logic [4:0] {
        ST_IDLE            = 5'd0,
        ST_HOMING          = 5'd1,
        ST_ROT_VIAL        = 5'd2,
        ST_DOWN_PICK       = 5'd3,
        ST_GRAB            = 5'd4,
        ST_UP              = 5'd5,
        ST_ROT_HOLE        = 5'd6,
        ST_DOWN_PLACE      = 5'd7,
        ST_RELEASE         = 5'd8,
        ST_UP_EMPTY        = 5'd9,
        ST_CLOSE_LID       = 5'd10,
        ST_MEASURING       = 5'd11,
        ST_OPEN_LID        = 5'd12,
        ST_DOWN_RETRIEVE   = 5'd13,
        ST_GRAB_AGAIN      = 5'd14,
        ST_UP_RETURN       = 5'd15,
        ST_ROT_BACK        = 5'd16,
        ST_DOWN_RETURN     = 5'd17,
        ST_RELEASE_HOME    = 5'd18,
        ST_UP_FINAL        = 5'd19,
        ST_DONE            = 5'd20,
        ST_ERROR           = 5'd21
    } t_state;

    typedef enum logic [1:0] {
        LIFT_STOP = 2'd0,
        LIFT_UP   = 2'd1,
        LIFT_DOWN = 2'd2
    } t_lift_cmd;

    typedef enum logic [1:0] {
        LID_STOP  = 2'd0,
        LID_CLOSE = 2'd1,
        LID_OPEN  = 2'd2
    } t_lid_cmd;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } t_step_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIFT_TIMEOUT  = 3'd0,
        CFG_REV_TIMEOUT   = 3'd1,
        CFG_GRAB_WAIT     = 3'd2,
        CFG_LID_TIMEOUT   = 3'd3,
        CFG_MEASURE_TIME  = 3'd4,
        CFG_HOLE_STEPS    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] lift_timeout_ms;
        logic [TIME_W-1:0] revolver_timeout_ms;
        logic [TIME_W-1:0] dwell_ms;
        logic [TIME_W-1:0] lid_timeout_ms;
        logic [TIME_W-1:0] measure_time_ms;
    } t_cfg;

    typedef struct packed {
        logic              run_enable;
        logic [TICK_W-1:0] tick_ms;
        logic              lift_at_top;
        logic [1:0]        lift_trigger_events;
        logic              revolver_at_vial;
        logic [1:0]        revolver_trigger_events;
        logic              revolver_busy;
        logic              lid_is_closed;
        logic              lid_is_open;
    } t_tick;

    typedef struct packed {
        t_state      state_code;
        t_lift_cmd   lift_drive;
        logic        magnet_closed;
        logic        revolver_turning;
        t_step_req   revolver_step_request;
        t_lid_cmd    lid_drive;
        logic [15:0] cycles_done;
        logic        fault;
    } t_result;

endpackage

// File: rtl/vhs_cfg_regs.sv
// ----------------------------------------------------------------------------
// vhs_cfg_regs
// Timing registers of the sequencer, written through the configuration
// channel. The hole step count belongs to the external stepper and is not
// held here.
// ----------------------------------------------------------------------------
module vhs_cfg_regs
    import vhs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TIME_W-1:0]     i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Store the written value in the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lift_timeout_ms     <= LIFT_TIMEOUT_RST;
            r_cfg.revolver_timeout_ms <= REV_TIMEOUT_RST;
            r_cfg.dwell_ms            <= GRAB_WAIT_RST;
            r_cfg.lid_timeout_ms      <= LID_TIMEOUT_RST;
            r_cfg.measure_time_ms     <= MEASURE_TIME_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LIFT_TIMEOUT: r_cfg.lift_timeout_ms     <= i_cfg_data;
                CFG_REV_TIMEOUT:  r_cfg.revolver_timeout_ms <= i_cfg_data;
                CFG_GRAB_WAIT:    r_cfg.dwell_ms            <= i_cfg_data;
                CFG_LID_TIMEOUT:  r_cfg.lid_timeout_ms      <= i_cfg_data;
                CFG_MEASURE_TIME: r_cfg.measure_time_ms     <= i_cfg_data;
                CFG_HOLE_STEPS:   ;
                default:          ;
            endcase
        end
    end

endmodule

// File: rtl/vhs_ctrl.sv
// ----------------------------------------------------------------------------
// vhs_ctrl
// Sequence state machine with its timer, trigger totals and actuator
// command registers. Works out one tick per advance and presents the
// result of that tick.
// ----------------------------------------------------------------------------
module vhs_ctrl
    import vhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_tick   i_tick,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // State registers
    t_state                 r_state, n_state;
    logic                   r_entry, n_entry;
    logic [ELAPSED_W-1:0]   r_elapsed, n_elapsed;
    logic                   r_left, n_left;
    logic [1:0]             r_lt_total, n_lt_total;
    logic [1:0]             r_rv_total, n_rv_total;
    logic [COUNT_BITS-1:0]  r_vial, n_vial;
    t_lift_cmd              r_lift_cmd, n_lift_cmd;
    logic                   r_magnet, n_magnet;
    logic                   r_rev_cmd, n_rev_cmd;
    t_lid_cmd               r_lid_cmd, n_lid_cmd;

    t_step_req              w_step;
    t_state                 w_succ;
    logic [ELAPSED_W:0]     w_el_sum;
    logic [ELAPSED_W-1:0]   w_el_cur;
    logic [2:0]             w_lt_sum;
    logic [2:0]             w_rv_sum;
    logic [1:0]             w_lt_sat;
    logic [1:0]             w_rv_sat;
    logic [TIME_W:0]        w_home_limit;
    logic                   w_lift_over;
    logic                   w_rev_over;
    logic                   w_grab_over;
    logic                   w_lid_over;
    logic                   w_home_over;
    logic                   w_meas_done;
    logic [1:0]             w_need;
    logic [31:0]            w_vial_ext;

    // Timer grows on every tick but the entry tick, saturating
    assign w_el_sum = {1'b0, r_elapsed} + (ELAPSED_W+1)'(i_tick.tick_ms);
    assign w_el_cur = r_entry ? r_elapsed :
                      (w_el_sum[ELAPSED_W] ? ELAPSED_MAX : w_el_sum[ELAPSED_W-1:0]);

    // Trigger totals saturate at three
    assign w_lt_sum = {1'b0, r_lt_total} + {1'b0, i_tick.lift_trigger_events};
    assign w_rv_sum = {1'b0, r_rv_total} + {1'b0, i_tick.revolver_trigger_events};
    assign w_lt_sat = w_lt_sum[2] ? 2'd3 : w_lt_sum[1:0];
    assign w_rv_sat = w_rv_sum[2] ? 2'd3 : w_rv_sum[1:0];

    // Timeout compares on the updated timer
    assign w_home_limit = {1'b0, i_cfg.lift_timeout_ms} + {1'b0, i_cfg.revolver_timeout_ms};
    assign w_lift_over  = w_el_cur > ELAPSED_W'(i_cfg.lift_timeout_ms);
    assign w_rev_over   = w_el_cur > ELAPSED_W'(i_cfg.revolver_timeout_ms);
    assign w_grab_over  = w_el_cur > ELAPSED_W'(i_cfg.dwell_ms);
    assign w_lid_over   = w_el_cur > ELAPSED_W'(i_cfg.lid_timeout_ms);
    assign w_home_over  = w_el_cur > ELAPSED_W'(w_home_limit);
    assign w_meas_done  = w_el_cur >= ELAPSED_W'(i_cfg.measure_time_ms);

    // The normal successor is the next code; DONE loops back explicitly
    assign w_succ = t_state'(5'(r_state) + 5'd1);
    assign w_need = (r_state == ST_DOWN_PLACE) ? 2'd2 : 2'd1;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_entry    <= 1'b1;
            r_elapsed  <= '0;
            r_left     <= 1'b0;
            r_lt_total <= '0;
            r_rv_total <= '0;
            r_vial     <= '0;
            r_lift_cmd <= LIFT_STOP;
            r_magnet   <= 1'b0;
            r_rev_cmd  <= 1'b0;
            r_lid_cmd  <= LID_STOP;
        end else if (i_advance) begin
            r_state    <= n_state;
            r_entry    <= n_entry;
            r_elapsed  <= n_elapsed;
            r_left     <= n_left;
            r_lt_total <= n_lt_total;
            r_rv_total <= n_rv_total;
            r_vial     <= n_vial;
            r_lift_cmd <= n_lift_cmd;
            r_magnet   <= n_magnet;
            r_rev_cmd  <= n_rev_cmd;
            r_lid_cmd  <= n_lid_cmd;
        end
    end

    // Next state and commands for one tick
    always_comb begin
        n_state    = r_state;
        n_entry    = r_entry;
        n_elapsed  = r_elapsed;
        n_left     = r_left;
        n_lt_total = r_lt_total;
        n_rv_total = r_rv_total;
        n_vial     = r_vial;
        n_lift_cmd = r_lift_cmd;
        n_magnet   = r_magnet;
        n_rev_cmd  = r_rev_cmd;
        n_lid_cmd  = r_lid_cmd;
        w_step     = STEP_NONE;

        if (!i_tick.run_enable) begin
            // Stop everything and drop back to idle
            n_lift_cmd = LIFT_STOP;
            n_magnet   = 1'b0;
            n_rev_cmd  = 1'b0;
            n_lid_cmd  = LID_STOP;
            n_state    = ST_IDLE;
            n_entry    = 1'b1;
            n_elapsed  = '0;
            n_vial     = '0;
        end else begin
            n_lt_total = w_lt_sat;
            n_rv_total = w_rv_sat;
            n_elapsed  = w_el_cur;
            n_entry    = 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (r_entry) begin
                        n_lift_cmd = LIFT_STOP;
                        n_magnet   = 1'b0;
                        n_rev_cmd  = 1'b0;
                        n_lid_cmd  = LID_STOP;
                    end
                    n_state   = w_succ;
                    n_entry   = 1'b1;
                    n_elapsed = '0;
                end

                ST_HOMING: begin
                    if (r_entry) begin
                        n_left     = 1'b0;
                        n_magnet   = 1'b1;
                        n_lift_cmd = LIFT_UP;
                        n_rev_cmd  = 1'b1;
                    end
                    if (!n_left && !i_tick.revolver_at_vial) n_left = 1'b1;
                    if (i_tick.lift_at_top) n_lift_cmd = LIFT_STOP;
                    if (n_left && i_tick.revolver_at_vial) n_rev_cmd = 1'b0;
                    if (i_tick.lift_at_top && n_left && i_tick.revolver_at_vial) begin
                        n_state   = w_succ;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end else if (w_home_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_ROT_VIAL: begin
                    if (r_entry) n_magnet = 1'b1;
                    n_state   = w_succ;
                    n_entry   = 1'b1;
                    n_elapsed = '0;
                end

                ST_DOWN_PICK, ST_DOWN_PLACE, ST_DOWN_RETRIEVE, ST_DOWN_RETURN: begin
                    if (r_entry) begin
                        n_left     = 1'b0;
                        n_lt_total = '0;
                        n_lift_cmd = LIFT_DOWN;
                    end
                    if (!n_left && !i_tick.lift_at_top) n_left = 1'b1;
                    if (n_left && (n_lt_total >= w_need)) begin
                        n_lift_cmd = LIFT_STOP;
                        n_state    = w_succ;
                        n_entry    = 1'b1;
                        n_elapsed  = '0;
                    end else if (w_lift_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_GRAB, ST_GRAB_AGAIN, ST_RELEASE, ST_RELEASE_HOME: begin
                    if (r_entry && (r_state == ST_RELEASE || r_state == ST_RELEASE_HOME))
                        n_magnet = 1'b0;
                    if (w_grab_over) begin
                        n_state   = w_succ;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_UP, ST_UP_EMPTY, ST_UP_FINAL: begin
                    if (r_entry) begin
                        n_left     = 1'b0;
                        n_lift_cmd = LIFT_UP;
                    end
                    if (!n_left && !i_tick.lift_at_top) n_left = 1'b1;
                    if (n_left && i_tick.lift_at_top) begin
                        n_lift_cmd = LIFT_STOP;
                        n_state    = w_succ;
                        n_entry    = 1'b1;
                        n_elapsed  = '0;
                    end else if (w_lift_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_UP_RETURN: begin
                    if (r_entry) begin
                        n_left     = 1'b0;
                        n_lt_total = '0;
                        n_lift_cmd = LIFT_UP;
                    end
                    if (!n_left && !i_tick.lift_at_top) n_left = 1'b1;
                    if (n_left && (n_lt_total >= 2'd2)) begin
                        n_lift_cmd = LIFT_STOP;
                        n_state    = w_succ;
                        n_entry    = 1'b1;
                        n_elapsed  = '0;
                    end else if (w_lift_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_ROT_HOLE, ST_ROT_BACK: begin
                    // Request the stepped move on entry; it counts as running
                    if (r_entry) begin
                        w_step = (r_state == ST_ROT_HOLE) ? STEP_CW : STEP_CCW;
                    end else if (!i_tick.revolver_busy) begin
                        n_state   = w_succ;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end else if (w_rev_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_CLOSE_LID: begin
                    if (r_entry) begin
                        n_magnet  = 1'b1;
                        n_lid_cmd = LID_CLOSE;
                    end
                    if (i_tick.lid_is_closed) begin
                        n_lid_cmd = LID_STOP;
                        n_state   = w_succ;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end else if (w_lid_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_MEASURING: begin
                    if (w_meas_done) begin
                        n_state   = w_succ;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_OPEN_LID: begin
                    if (r_entry) n_lid_cmd = LID_OPEN;
                    if (i_tick.lid_is_open) begin
                        n_lid_cmd = LID_STOP;
                        n_state   = w_succ;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end else if (w_lid_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_DONE: begin
                    // Count the vial and advance the revolver to the next one
                    if (r_entry) begin
                        n_vial     = r_vial + COUNT_BITS'(1);
                        n_magnet   = 1'b1;
                        n_rv_total = '0;
                        n_rev_cmd  = 1'b1;
                    end
                    if (n_rv_total >= 2'd1) begin
                        n_rev_cmd = 1'b0;
                        n_state   = ST_DOWN_PICK;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end else if (w_rev_over) begin
                        n_state   = ST_ERROR;
                        n_entry   = 1'b1;
                        n_elapsed = '0;
                    end
                end

                ST_ERROR: begin
                    if (r_entry) begin
                        n_lift_cmd = LIFT_STOP;
                        n_magnet   = 1'b0;
                        n_rev_cmd  = 1'b0;
                        n_lid_cmd  = LID_STOP;
                    end
                end

                default: begin
                    n_state   = ST_ERROR;
                    n_entry   = 1'b1;
                    n_elapsed = '0;
                end
            endcase
        end
    end

    // Result of the tick, taken after the update
    assign w_vial_ext = 32'(n_vial);

    always_comb begin
        o_result.state_code            = n_state;
        o_result.lift_drive            = n_lift_cmd;
        o_result.magnet_closed         = n_magnet;
        o_result.revolver_turning      = n_rev_cmd;
        o_result.revolver_step_request = w_step;
        o_result.lid_drive             = n_lid_cmd;
        o_result.cycles_done           = w_vial_ext[15:0];
        o_result.fault                 = (n_state == ST_ERROR);
    end

`ifndef NO_ASSERTIONS
    // Run low always lands in idle with the entry pending and the timer clear
    a_run_low_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_tick.run_enable |=>
            r_state == ST_IDLE && r_entry && r_elapsed == '0 && r_vial == '0)
        else $error("run low did not return the sequence to idle");

    // Error holds while run stays high
    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_tick.run_enable && r_state == ST_ERROR |=> r_state == ST_ERROR)
        else $error("error state left while running");

    // Without an advance nothing of the sequence moves
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_state) && $stable(r_elapsed) && $stable(r_vial))
        else $error("sequence state changed without a transfer");

    // A change of state restarts the timer and marks the entry tick
    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_tick.run_enable && n_state != r_state |=>
            r_entry && r_elapsed == '0)
        else $error("state change without timer restart");

    // A step request only comes on the entry tick of a stepped rotation
    a_step_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step != STEP_NONE |->
            r_entry && (r_state == ST_ROT_HOLE || r_state == ST_ROT_BACK))
        else $error("step request outside a stepped rotation entry");
`endif

endmodule

// File: rtl/vial_handling_sequencer.sv
// A result passes through the input register, then the result register; the tick is
// computed combinationally between them.
// Throughput: one tick per cycle, limited only by the output side taking results.
// Reset (i_rst_n low at a clock edge): sequence in idle with entry pending, timer,
// trigger totals and vial count cleared, actuators stopped, registers at defaults.
// ----------------------------------------------------------------------------
// vial_handling_sequencer
// Pick, place, measure and return sequencer for one vial handling station.
// Each input transfer is one control tick; each tick gives one command result.
// ----------------------------------------------------------------------------
module vial_handling_sequencer
    import vhs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Tick stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] run_enable, [10:1] tick_ms, [11] lift_at_top,
    // [13:12] lift_trigger_events, [14] revolver_at_vial,
    // [16:15] revolver_trigger_events, [17] revolver_busy,
    // [18] lid_is_closed, [19] lid_is_open, [23:20] zero
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // Command stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] state_code, [6:5] lift_drive, [7] magnet_closed,
    // [8] revolver_turning, [10:9] revolver_step_request, [12:11] lid_drive,
    // [28:13] cycles_done, [29] fault, [31:30] zero
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TIME_W-1:0]     i_cfg_data
);

    logic                 r_in_valid;
    t_tick                r_in_tick;
    logic                 r_out_valid;
    logic [M_DATA_W-1:0]  r_out_data;
    logic                 w_advance;
    logic                 w_s_xfer;
    t_cfg                 w_cfg;
    t_result              w_result;

    // Move the held tick on when the result register is free or being emptied
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_xfer      = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_in_tick.run_enable              <= s_axis_tdata[0];
            r_in_tick.tick_ms                 <= s_axis_tdata[10:1];
            r_in_tick.lift_at_top             <= s_axis_tdata[11];
            r_in_tick.lift_trigger_events     <= s_axis_tdata[13:12];
            r_in_tick.revolver_at_vial        <= s_axis_tdata[14];
            r_in_tick.revolver_trigger_events <= s_axis_tdata[16:15];
            r_in_tick.revolver_busy           <= s_axis_tdata[17];
            r_in_tick.lid_is_closed           <= s_axis_tdata[18];
            r_in_tick.lid_is_open             <= s_axis_tdata[19];
        end
    end

    vhs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    vhs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_tick    (r_in_tick),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {2'b00,
                           w_result.fault,
                           w_result.cycles_done,
                           w_result.lid_drive,
                           w_result.revolver_step_request,
                           w_result.revolver_turning,
                           w_result.magnet_closed,
                           w_result.lift_drive,
                           w_result.state_code};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
